>>> design/lrq_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lrq_pkg
// Shared widths, operation codes and cell control type for the recency queue.
// ----------------------------------------------------------------------------
package lrq_pkg;

    localparam int FUNC_WIDTH       = 2;
    localparam int VALUE_PORT_WIDTH = 32;
    localparam int INDEX_WIDTH      = 3;
    localparam int COUNT_WIDTH      = 4;

    localparam int DEPTH_DEFAULT       = 8;
    localparam int VALUE_WIDTH_DEFAULT = 32;

    typedef logic [FUNC_WIDTH-1:0] func_t;

    localparam func_t FUNC_PUSH = 2'd0;
    localparam func_t FUNC_USE  = 2'd1;
    localparam func_t FUNC_POP  = 2'd2;
    localparam func_t FUNC_READ = 2'd3;

    typedef struct packed {
        logic push_op;
        logic use_op;
        logic tail_sel;
        logic valid;
    } cell_ctrl_t;

endpackage
`default_nettype wire

>>> design/lrq_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lrq_if
// Valid/ready channels for recency queue requests and responses.
// ----------------------------------------------------------------------------
interface lrq_req_if;
    logic                                   valid;
    logic                                   ready;
    logic [lrq_pkg::FUNC_WIDTH-1:0]         func;
    logic [lrq_pkg::VALUE_PORT_WIDTH-1:0]   value;
    logic [lrq_pkg::INDEX_WIDTH-1:0]        index;

    modport source (output valid, output func, output value, output index, input ready);
    modport sink (input valid, input func, input value, input index, output ready);
endinterface

interface lrq_rsp_if;
    logic                                   valid;
    logic                                   ready;
    logic                                   ok;
    logic [lrq_pkg::VALUE_PORT_WIDTH-1:0]   read_value;
    logic [lrq_pkg::COUNT_WIDTH-1:0]        count;

    modport source (output valid, output ok, output read_value, output count, input ready);
    modport sink (input valid, input ok, input read_value, input count, output ready);
endinterface
`default_nettype wire

>>> design/lru_recency_queue_unit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lru_recency_queue_unit
// Least-to-most recently used value queue with push, use, pop and read.
// Response: response word valid in the cycle after the request word is taken.
// Throughput: one word per cycle while the response side is ready; the whole cell row updates on each accepted word.
// Reset: fill count and response valid clear; stored entries are left as is.
// ----------------------------------------------------------------------------
module lru_recency_queue_unit #(
    parameter int DEPTH       = lrq_pkg::DEPTH_DEFAULT,
    parameter int VALUE_WIDTH = lrq_pkg::VALUE_WIDTH_DEFAULT
) (
    input  wire logic  clk,
    input  wire logic  rst_n,
    lrq_req_if.sink    req,
    lrq_rsp_if.source  rsp
);
    import lrq_pkg::*;

    localparam int CW = $clog2(DEPTH + 1);

    logic                               accept;
    logic [CW-1:0]                      count_reg;
    logic [CW-1:0]                      count_next;
    logic                               rsp_valid_reg;
    logic                               ok_reg;
    logic                               ok_next;
    logic [VALUE_PORT_WIDTH-1:0]        read_value_reg;
    logic [VALUE_PORT_WIDTH-1:0]        read_value_next;
    logic [COUNT_WIDTH-1:0]             rsp_count_reg;
    logic [7:0]                         count_wide;
    logic [63:0]                        value_wide;
    logic [63:0]                        entry_wide;
    logic [VALUE_WIDTH-1:0]             val;
    logic [VALUE_WIDTH-1:0]             rd_entry;
    logic                               rd_ok;
    logic                               full;
    logic                               found;
    logic [DEPTH-1:0][VALUE_WIDTH-1:0]  entries;

    assign req.ready  = ~rsp_valid_reg | rsp.ready;
    assign accept     = req.valid & req.ready;
    assign value_wide = 64'(req.value);
    assign val        = value_wide[VALUE_WIDTH-1:0];
    assign full       = (count_reg == CW'(DEPTH));
    assign rd_ok      = (8'(req.index) < 8'(count_reg));

    lrq_chain #(
        .DEPTH       (DEPTH),
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_chain (
        .clk     (clk),
        .en      (accept),
        .func    (req.func),
        .count   (count_reg),
        .val     (val),
        .entries (entries),
        .found   (found)
    );

    always_comb
    begin
        rd_entry = '0;
        for (int i = 0; i < DEPTH; i++)
        begin
            if (8'(req.index) == 8'(i))
            begin
                rd_entry = entries[i];
            end
        end
    end

    assign entry_wide = 64'(rd_entry);

    always_comb
    begin
        count_next      = count_reg;
        ok_next         = 1'b0;
        read_value_next = '0;
        unique case (req.func)
            FUNC_PUSH:
            begin
                ok_next = ~full;
                if (!full)
                begin
                    count_next = count_reg + CW'(1);
                end
            end
            FUNC_USE:
            begin
                ok_next = found;
            end
            FUNC_POP:
            begin
                ok_next = (count_reg != '0);
                if (count_reg != '0)
                begin
                    count_next = count_reg - CW'(1);
                end
            end
            FUNC_READ:
            begin
                ok_next = rd_ok;
                if (rd_ok)
                begin
                    read_value_next = entry_wide[VALUE_PORT_WIDTH-1:0];
                end
            end
        endcase
    end

    assign count_wide = 8'(count_next);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                count_reg     <= count_next;
                rsp_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            ok_reg         <= ok_next;
            read_value_reg <= read_value_next;
            rsp_count_reg  <= count_wide[COUNT_WIDTH-1:0];
        end
    end

    assign rsp.valid      = rsp_valid_reg;
    assign rsp.ok         = ok_reg;
    assign rsp.read_value = read_value_reg;
    assign rsp.count      = rsp_count_reg;

endmodule
`default_nettype wire

>>> design/lrq_cell.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lrq_cell
// One queue slot: match against the operand, shift from the right neighbor,
// or load the operand as the newest entry.
// ----------------------------------------------------------------------------
module lrq_cell #(
    parameter int VALUE_WIDTH = lrq_pkg::VALUE_WIDTH_DEFAULT
) (
    input  wire logic                   clk,
    input  wire logic                   en,
    input  wire lrq_pkg::cell_ctrl_t    ctrl,
    input  wire logic [VALUE_WIDTH-1:0] val,
    input  wire logic [VALUE_WIDTH-1:0] right_entry,
    input  wire logic                   shift_in,
    output logic                        shift_out,
    output logic [VALUE_WIDTH-1:0]      entry
);
    import lrq_pkg::*;

    logic [VALUE_WIDTH-1:0] entry_reg;
    logic [VALUE_WIDTH-1:0] entry_next;
    logic                   match;
    logic                   load;

    assign match     = ctrl.use_op & ctrl.valid & (entry_reg == val);
    assign shift_out = shift_in | match;
    assign load      = ctrl.tail_sel & (ctrl.push_op | (ctrl.use_op & shift_out));

    always_comb
    begin
        priority if (load)
        begin
            entry_next = val;
        end
        else if (shift_out)
        begin
            entry_next = right_entry;
        end
        else
        begin
            entry_next = entry_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            entry_reg <= entry_next;
        end
    end

    assign entry = entry_reg;

endmodule
`default_nettype wire

>>> design/lrq_chain.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lrq_chain
// Row of queue cells, oldest at position 0; decodes per-cell control and
// links the shift chain.
// ----------------------------------------------------------------------------
module lrq_chain #(
    parameter int DEPTH       = lrq_pkg::DEPTH_DEFAULT,
    parameter int VALUE_WIDTH = lrq_pkg::VALUE_WIDTH_DEFAULT,
    localparam int CW         = $clog2(DEPTH + 1)
) (
    input  wire logic                                clk,
    input  wire logic                                en,
    input  wire logic [lrq_pkg::FUNC_WIDTH-1:0]      func,
    input  wire logic [CW-1:0]                       count,
    input  wire logic [VALUE_WIDTH-1:0]              val,
    output logic [DEPTH-1:0][VALUE_WIDTH-1:0]        entries,
    output logic                                     found
);
    import lrq_pkg::*;

    logic             push_op;
    logic             use_op;
    logic             pop_op;
    logic             full;
    logic [DEPTH:0]   shift;

    assign push_op  = (func == FUNC_PUSH);
    assign use_op   = (func == FUNC_USE);
    assign pop_op   = (func == FUNC_POP);
    assign full     = (count == CW'(DEPTH));
    assign shift[0] = (push_op & full) | (pop_op & (count != '0));
    assign found    = use_op & shift[DEPTH];

    for (genvar i = 0; i < DEPTH; i++)
    begin : g_cell
        cell_ctrl_t             ctrl;
        logic [VALUE_WIDTH-1:0] right_entry;

        assign ctrl.push_op  = push_op;
        assign ctrl.use_op   = use_op;
        assign ctrl.valid    = (count > CW'(i));
        assign ctrl.tail_sel = push_op ? (full ? (i == DEPTH - 1) : (count == CW'(i)))
                                       : (count == CW'(i + 1));

        if (i == DEPTH - 1)
        begin : g_last
            assign right_entry = entries[i];
        end
        else
        begin : g_inner
            assign right_entry = entries[i + 1];
        end

        lrq_cell #(
            .VALUE_WIDTH (VALUE_WIDTH)
        ) u_cell (
            .clk         (clk),
            .en          (en),
            .ctrl        (ctrl),
            .val         (val),
            .right_entry (right_entry),
            .shift_in    (shift[i]),
            .shift_out   (shift[i + 1]),
            .entry       (entries[i])
        );
    end

endmodule
`default_nettype wire

>>> verif/lru_recency_queue_unit_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lru_recency_queue_unit_checker
// Watches the request and response channels of the recency queue. Keeps its
// own recency list and predicts the response word for each accepted request.
// It then compares every accepted response with the oldest prediction.
// Reports a running failure count and the number of responses still owed.
// ----------------------------------------------------------------------------
module lru_recency_queue_unit_checker (
    input  wire logic clk,
    input  wire logic rst_n,
    lrq_req_if        req,
    lrq_rsp_if        rsp,
    output int        fail_count,
    output int        outstanding
);
    import lrq_pkg::*;

    localparam int QUEUE_DEPTH    = DEPTH_DEFAULT;
    localparam int REPORT_LIMIT   = 10;

    typedef struct packed {
        logic                         ok;
        logic [VALUE_PORT_WIDTH-1:0]  read_value;
        logic [COUNT_WIDTH-1:0]       count;
    } rsp_word_t;

    logic [VALUE_PORT_WIDTH-1:0] recency_list [$];
    rsp_word_t                   expected_rsp_q [$];
    int                          fail_total;

    function automatic rsp_word_t apply_request(
        input func_t                       op,
        input logic [VALUE_PORT_WIDTH-1:0] value,
        input logic [INDEX_WIDTH-1:0]      index
    );
        rsp_word_t r;
        int        hit;
        r   = '0;
        hit = -1;
        case (op)
            FUNC_PUSH:
            begin
                if (recency_list.size() >= QUEUE_DEPTH)
                begin
                    recency_list.delete(0);
                    r.ok = 1'b0;
                end
                else
                begin
                    r.ok = 1'b1;
                end
                recency_list.push_back(value);
            end
            FUNC_USE:
            begin
                foreach (recency_list[i])
                begin
                    if (hit < 0 && recency_list[i] == value)
                        hit = i;
                end
                if (hit >= 0)
                begin
                    recency_list.delete(hit);
                    recency_list.push_back(value);
                    r.ok = 1'b1;
                end
            end
            FUNC_POP:
            begin
                if (recency_list.size() > 0)
                begin
                    recency_list.delete(0);
                    r.ok = 1'b1;
                end
            end
            FUNC_READ:
            begin
                if (int'(index) < recency_list.size())
                begin
                    r.read_value = recency_list[index];
                    r.ok         = 1'b1;
                end
            end
            default:
            begin
            end
        endcase
        r.count = COUNT_WIDTH'(recency_list.size());
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        rsp_word_t exp_word;
        if (!rst_n)
        begin
            recency_list.delete();
            expected_rsp_q.delete();
            fail_total  = 0;
            fail_count  <= 0;
            outstanding <= 0;
        end
        else
        begin
            if (rsp.valid === 1'b1 && rsp.ready === 1'b1)
            begin
                if (expected_rsp_q.size() == 0)
                begin
                    fail_total++;
                    if (fail_total <= REPORT_LIMIT)
                        $display("%0t: response word with none expected: ok=%0b read_value=%08h count=%0d",
                                 $realtime, rsp.ok, rsp.read_value, rsp.count);
                end
                else
                begin
                    exp_word = expected_rsp_q.pop_front();
                    if (rsp.ok !== exp_word.ok || rsp.read_value !== exp_word.read_value
                        || rsp.count !== exp_word.count)
                    begin
                        fail_total++;
                        if (fail_total <= REPORT_LIMIT)
                            $display("%0t: mismatch: expected ok=%0b read_value=%08h count=%0d, got ok=%0b read_value=%08h count=%0d",
                                     $realtime, exp_word.ok, exp_word.read_value, exp_word.count,
                                     rsp.ok, rsp.read_value, rsp.count);
                    end
                end
            end
            if (req.valid === 1'b1 && req.ready === 1'b1)
                expected_rsp_q.push_back(apply_request(req.func, req.value, req.index));
            fail_count  <= fail_total;
            outstanding <= expected_rsp_q.size();
        end
    end

endmodule

>>> verif/lru_recency_queue_unit_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lru_recency_queue_unit_tb
// Drives the recency queue with a directed set of push, use, pop and read
// words that cover full, empty, duplicate and out-of-range cases. It then
// sends random words that alternate between filling and draining the queue.
// Both sides stall in random bursts. The receiver holds off once for a long
// stretch. The checker beside the block predicts and compares every response.
// ----------------------------------------------------------------------------
module lru_recency_queue_unit_tb;
    import lrq_pkg::*;

    localparam int RANDOM_WORDS   = 450;
    localparam int QUIET_FROM     = 390;
    localparam int HOLD_OFF_AT    = 120;
    localparam int HOLD_OFF_LEN   = 200;
    localparam int BIAS_SPAN      = 40;
    localparam int POOL_SIZE      = 10;
    localparam int DRAIN_CYCLES   = 4;
    localparam int CYCLE_LIMIT    = 200000;

    logic clk;
    logic rst_n;
    logic quiet_tail;
    logic hold_off_start;
    int   fail_count;
    int   outstanding;
    logic [VALUE_PORT_WIDTH-1:0] value_pool [POOL_SIZE];

    lrq_req_if req_ch ();
    lrq_rsp_if rsp_ch ();

    lru_recency_queue_unit #(
        .DEPTH       (DEPTH_DEFAULT),
        .VALUE_WIDTH (VALUE_WIDTH_DEFAULT)
    ) dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    lru_recency_queue_unit_checker checker_i (
        .clk         (clk),
        .rst_n       (rst_n),
        .req         (req_ch),
        .rsp         (rsp_ch),
        .fail_count  (fail_count),
        .outstanding (outstanding)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    initial
    begin : watchdog
        int cycle_count;
        for (cycle_count = 0; cycle_count < CYCLE_LIMIT; cycle_count++)
            @(posedge clk);
        $display("Some tests failed");
        $finish;
    end

    // hold off the response side in random bursts, once for a long stretch
    initial
    begin : rsp_ready_gen
        int held;
        logic long_done;
        long_done = 1'b0;
        rsp_ch.ready <= 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(posedge clk);
            if (hold_off_start && !long_done)
            begin
                long_done = 1'b1;
                rsp_ch.ready <= 1'b0;
                for (held = 0; held < HOLD_OFF_LEN; held++)
                    @(posedge clk);
                rsp_ch.ready <= 1'b1;
            end
            else if (!quiet_tail && $urandom_range(0, 7) == 0)
            begin
                rsp_ch.ready <= 1'b0;
                repeat ($urandom_range(1, 11)) @(posedge clk);
                rsp_ch.ready <= 1'b1;
            end
            else
            begin
                rsp_ch.ready <= 1'b1;
            end
        end
    end

    task automatic send_request(
        input func_t                       op,
        input logic [VALUE_PORT_WIDTH-1:0] value,
        input logic [INDEX_WIDTH-1:0]      index,
        input bit                          may_idle
    );
        if (may_idle && $urandom_range(0, 5) == 0)
        begin
            req_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 11)) @(posedge clk);
        end
        req_ch.valid <= 1'b1;
        req_ch.func  <= op;
        req_ch.value <= value;
        req_ch.index <= index;
        do
            @(posedge clk);
        while (req_ch.ready !== 1'b1);
    endtask

    initial
    begin : stimulus
        int                          n;
        int                          roll;
        bit                          fill_bias;
        func_t                       op;
        logic [VALUE_PORT_WIDTH-1:0] v;

        rst_n          <= 1'b0;
        quiet_tail     <= 1'b0;
        hold_off_start <= 1'b0;
        req_ch.valid   <= 1'b0;
        req_ch.func    <= FUNC_PUSH;
        req_ch.value   <= '0;
        req_ch.index   <= '0;

        value_pool[0] = '0;
        value_pool[1] = '1;
        for (n = 2; n < POOL_SIZE; n++)
            value_pool[n] = $urandom();

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // empty queue
        send_request(FUNC_READ, '0, 3'd0, 1'b1);
        send_request(FUNC_POP, '0, 3'd0, 1'b1);
        send_request(FUNC_USE, '0, 3'd0, 1'b1);
        // fill up, with a duplicate
        send_request(FUNC_PUSH, 32'h0000_0000, 3'd0, 1'b1);
        send_request(FUNC_PUSH, 32'hFFFF_FFFF, 3'd0, 1'b1);
        send_request(FUNC_PUSH, 32'h5555_5555, 3'd0, 1'b1);
        send_request(FUNC_PUSH, 32'hAAAA_AAAA, 3'd0, 1'b1);
        send_request(FUNC_PUSH, 32'h0000_0000, 3'd0, 1'b1);
        send_request(FUNC_PUSH, 32'h0000_0003, 3'd0, 1'b1);
        send_request(FUNC_PUSH, 32'h0000_0004, 3'd0, 1'b1);
        send_request(FUNC_PUSH, 32'h0000_0005, 3'd0, 1'b1);
        // push when full drops the oldest
        send_request(FUNC_PUSH, 32'h0000_0006, 3'd0, 1'b1);
        send_request(FUNC_PUSH, 32'h5555_5555, 3'd0, 1'b1);
        // oldest of two matches moves
        send_request(FUNC_USE, 32'h5555_5555, 3'd0, 1'b1);
        send_request(FUNC_USE, 32'h0000_0000, 3'd0, 1'b1);
        send_request(FUNC_USE, 32'h0000_0123, 3'd0, 1'b1);
        send_request(FUNC_READ, '0, 3'd0, 1'b1);
        send_request(FUNC_READ, '0, 3'd7, 1'b1);
        send_request(FUNC_POP, '0, 3'd0, 1'b1);
        send_request(FUNC_POP, '0, 3'd0, 1'b1);
        send_request(FUNC_READ, '0, 3'd6, 1'b1);
        send_request(FUNC_READ, '0, 3'd7, 1'b1);
        send_request(FUNC_READ, '0, 3'd5, 1'b1);

        for (n = 0; n < RANDOM_WORDS; n++)
        begin
            if (n == HOLD_OFF_AT)
                hold_off_start <= 1'b1;
            if (n == QUIET_FROM)
                quiet_tail <= 1'b1;
            fill_bias = ((n / BIAS_SPAN) % 2) == 0;
            roll = $urandom_range(0, 99);
            if (fill_bias)
                op = (roll < 45) ? FUNC_PUSH : (roll < 70) ? FUNC_USE :
                     (roll < 80) ? FUNC_POP : FUNC_READ;
            else
                op = (roll < 20) ? FUNC_PUSH : (roll < 40) ? FUNC_USE :
                     (roll < 75) ? FUNC_POP : FUNC_READ;
            if ($urandom_range(0, 9) == 0)
                v = $urandom();
            else
                v = value_pool[$urandom_range(0, POOL_SIZE - 1)];
            send_request(op, v, INDEX_WIDTH'($urandom_range(0, 7)), n < QUIET_FROM);
        end

        req_ch.valid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (fail_count == 0 && outstanding == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
